>>> sv/cpsm_pkg.sv
// ----------------------------------------------------------------------------
// cpsm_pkg
// shared types, codes and prefix helpers for the cidr prefix set matcher
// ----------------------------------------------------------------------------
package cpsm_pkg;

    localparam int unsigned ADDR_BITS = 128;

    localparam logic [7:0] V4_BITS = 8'd32;
    localparam logic [7:0] V6_BITS = 8'd128;

    // item kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // one stored prefix
    typedef struct packed {
        logic                 fam;
        logic [ADDR_BITS-1:0] prefix;
        logic [7:0]           len;
    } t_entry;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    // length in 1..32 for ipv4, 1..128 for ipv6
    function automatic logic len_ok(input logic fam, input logic [7:0] len);
        logic [7:0] max_len;
        max_len = fam ? V6_BITS : V4_BITS;
        return (len != 8'd0) && (len <= max_len);
    endfunction

    // leading-bits mask; ipv4 lives in bits 31:0
    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic fam,
                                                         input logic [7:0] len);
        logic [ADDR_BITS-1:0] m6;
        logic [31:0]          m4;
        m6 = ~({ADDR_BITS{1'b1}} >> len);
        m4 = ~(32'hFFFF_FFFF >> len);
        return fam ? m6 : {{(ADDR_BITS-32){1'b0}}, m4};
    endfunction

endpackage

>>> sv/cpsm_ram.sv
// ----------------------------------------------------------------------------
// cpsm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cpsm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/cpsm_match.sv
// ----------------------------------------------------------------------------
// cpsm_match
// shared masked comparator: one stored entry against the current address
// ----------------------------------------------------------------------------
module cpsm_match
    import cpsm_pkg::*;
(
    input  logic                 i_is_insert,
    input  logic                 i_fam,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [7:0]           i_len,
    input  t_entry               i_entry,
    output logic [ADDR_BITS-1:0] o_key,
    output logic                 o_match
);

    logic [7:0] sel_len;
    logic       key_eq;

    // insert masks with its own length, lookup with the stored one
    assign sel_len = i_is_insert ? i_len : i_entry.len;
    assign o_key   = i_addr & prefix_mask(i_fam, sel_len);
    assign key_eq  = (o_key == i_entry.prefix) && (i_entry.fam == i_fam);

    always_comb begin
        if (i_is_insert) begin
            o_match = key_eq && (i_entry.len == i_len);
        end else begin
            o_match = key_eq && len_ok(i_fam, i_entry.len);
        end
    end

endmodule

>>> sv/cidr_prefix_set_match.sv
// sequence: insert and lookup scan every entry, then drain, decide and report the result
//   word; an insert that writes a new entry passes through a write state before reporting
// clear, a rejected length and an unused kind skip the scan and go straight to their word
// flow: a new word is taken only after the last one's result is loaded for output; the entry
//   scan through the single ram read port and the one shared masked comparator sets the pace
// reset: valid bits and control clear at once, entry ram keeps no reset, no clearing pass
// ----------------------------------------------------------------------------
// cidr_prefix_set_match
// bounded table of ipv4/ipv6 cidr prefixes with insert, lookup and clear,
// scanned one entry per cycle through a shared masked comparator
// ----------------------------------------------------------------------------
module cidr_prefix_set_match
    import cpsm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_is_v6,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [7:0]  i_prefix_length,
    // result word
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted_or_hit,
    output logic        o_table_full
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    // control state
    t_state                 r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic                   r_rd_vld, n_rd_vld;
    logic                   r_out_vld, n_out_vld;

    // working registers of the current word
    logic [1:0]             r_kind, n_kind;
    logic                   r_fam, n_fam;
    logic [ADDR_BITS-1:0]   r_addr, n_addr;
    logic [7:0]             r_len, n_len;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_rd_ent_vld, n_rd_ent_vld;
    logic                   r_match, n_match;
    logic                   r_free_found, n_free_found;
    logic [AW-1:0]          r_free_idx, n_free_idx;
    logic                   r_res_hit, n_res_hit;
    logic                   r_res_full, n_res_full;
    logic                   r_out_hit, n_out_hit;
    logic                   r_out_full, n_out_full;

    logic                   in_fire;
    logic                   ram_re;
    logic                   ram_we;
    t_entry                 ram_rdata;
    t_entry                 ram_wdata;
    logic [ADDR_BITS-1:0]   cmp_key;
    logic                   cmp_match;
    logic                   is_insert;

    assign o_in_ready = r_state == ST_IDLE;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_insert  = r_kind == KIND_INSERT;

    // entry store, one read per scan cycle
    cpsm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // the one comparator; its key is also the masked prefix for a write
    cpsm_match u_match (
        .i_is_insert (is_insert),
        .i_fam       (r_fam),
        .i_addr      (r_addr),
        .i_len       (r_len),
        .i_entry     (ram_rdata),
        .o_key       (cmp_key),
        .o_match     (cmp_match)
    );

    assign ram_wdata.fam    = r_fam;
    assign ram_wdata.prefix = cmp_key;
    assign ram_wdata.len    = r_len;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_rd_vld     = 1'b0;
        n_out_vld    = r_out_vld;
        n_kind       = r_kind;
        n_fam        = r_fam;
        n_addr       = r_addr;
        n_len        = r_len;
        n_idx        = r_idx;
        n_rd_idx     = r_rd_idx;
        n_rd_ent_vld = r_rd_ent_vld;
        n_match      = r_match;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res_hit    = r_res_hit;
        n_res_full   = r_res_full;
        n_out_hit    = r_out_hit;
        n_out_full   = r_out_full;
        ram_re       = 1'b0;
        ram_we       = 1'b0;

        // result word taken
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        // entry read in the previous cycle: first free slot, or a match
        if (r_rd_vld) begin
            if (!r_rd_ent_vld) begin
                if (!r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
            end else if (cmp_match) begin
                n_match = 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_kind       = i_kind;
                    n_fam        = i_is_v6;
                    // ipv4 keeps only bits 31:0
                    n_addr       = i_is_v6 ? {i_addr_high, i_addr_low}
                                           : {{(ADDR_BITS-32){1'b0}}, i_addr_low[31:0]};
                    n_len        = i_prefix_length;
                    n_idx        = '0;
                    n_match      = 1'b0;
                    n_free_found = 1'b0;
                    n_res_hit    = 1'b0;
                    n_res_full   = 1'b0;
                    case (i_kind)
                        KIND_INSERT: begin
                            if (len_ok(i_is_v6, i_prefix_length)) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        KIND_LOOKUP: begin
                            n_state = ST_SCAN;
                        end
                        KIND_CLEAR: begin
                            n_valid   = '0;
                            n_res_hit = 1'b1;
                            n_state   = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // one entry a cycle, valid bit travels with the read
                ram_re       = 1'b1;
                n_rd_vld     = 1'b1;
                n_rd_idx     = r_idx;
                n_rd_ent_vld = r_valid[r_idx];
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_DRAIN: begin
                // last entry compared this cycle
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (is_insert) begin
                    if (r_match) begin
                        // duplicate uses no entry
                        n_res_hit = 1'b1;
                        n_state   = ST_DONE;
                    end else if (!r_free_found) begin
                        n_res_full = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end else begin
                    n_res_hit = r_match;
                    n_state   = ST_DONE;
                end
            end
            ST_WRITE: begin
                // new prefix into the lowest free slot
                ram_we              = 1'b1;
                n_valid[r_free_idx] = 1'b1;
                n_res_hit           = 1'b1;
                n_state             = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_hit  = r_res_hit;
                    n_out_full = r_res_full;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_fam        <= n_fam;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_rd_ent_vld <= n_rd_ent_vld;
        r_match      <= n_match;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res_hit    <= n_res_hit;
        r_res_full   <= n_res_full;
        r_out_hit    <= n_out_hit;
        r_out_full   <= n_out_full;
    end

    assign o_out_valid       = r_out_vld;
    assign o_accepted_or_hit = r_out_hit;
    assign o_table_full      = r_out_full;

    // a refused insert never reports acceptance
    a_full_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_hit && r_out_full))
        else $error("table_full and accepted_or_hit both set");

    // a write only goes to a slot the scan found free
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (r_free_found && !r_valid[r_free_idx]))
        else $error("insert writes an occupied or unknown slot");

    // clear empties the whole table at once
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_kind == KIND_CLEAR)) |=> (r_valid == '0))
        else $error("valid bits left after clear");

    // no entry read is still in flight when the verdict is taken
    a_decide_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> !r_rd_vld)
        else $error("entry read pending at decision");

    // a result is only produced after the previous word left
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> ($stable(r_out_hit) && $stable(r_out_full)))
        else $error("pending result word overwritten");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for cidr_prefix_set_match: a shadow of the prefix
// table predicts every result word, with random idling on both channels
// ----------------------------------------------------------------------------
import cpsm_pkg::*;

localparam int TABLE_DEPTH = 64;

// kind code the block leaves unused
localparam logic [1:0] KIND_UNUSED = 2'd3;

// one input word as it goes onto the ports
typedef struct packed {
    logic [1:0]  kind;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  len;
} t_prefix_cmd;

typedef struct packed {
    logic hit;
    logic full;
} t_prefix_reply;

// leading len bits of the address, ipv4 sits in bits 31:0
function automatic logic [127:0] lead_mask(logic v6, logic [7:0] len);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 128; b++) begin
        if (b < int'(len) && (v6 || b < 32)) m[(v6 ? 127 : 31) - b] = 1'b1;
    end
    return m;
endfunction

// shadow copy of the prefix table plus the replies still owed by the block
class t_prefix_shadow;
    logic          slot_used [TABLE_DEPTH];
    logic          slot_v6   [TABLE_DEPTH];
    logic [127:0]  slot_bits [TABLE_DEPTH];
    logic [7:0]    slot_len  [TABLE_DEPTH];
    t_prefix_reply expected_replies[$];
    int            errors;

    function new();
        errors = 0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void note_word(t_prefix_cmd c);
        logic [127:0]  addr;
        logic [7:0]    max_len;
        int            free_slot;
        logic          dup;
        t_prefix_reply r;
        r         = '0;
        free_slot = -1;
        dup       = 1'b0;
        addr      = c.v6 ? {c.hi, c.lo} : {96'd0, c.lo[31:0]};
        max_len   = c.v6 ? V6_BITS : V4_BITS;
        case (c.kind)
            KIND_INSERT: begin
                if (c.len != 8'd0 && c.len <= max_len) begin
                    addr &= lead_mask(c.v6, c.len);
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!slot_used[i]) begin
                            if (free_slot < 0) free_slot = i;
                        end else if (slot_v6[i] == c.v6 && slot_len[i] == c.len &&
                                     slot_bits[i] == addr) begin
                            dup = 1'b1;
                        end
                    end
                    if (dup) begin
                        r.hit = 1'b1;
                    end else if (free_slot < 0) begin
                        r.full = 1'b1;
                    end else begin
                        slot_used[free_slot] = 1'b1;
                        slot_v6[free_slot]   = c.v6;
                        slot_bits[free_slot] = addr;
                        slot_len[free_slot]  = c.len;
                        r.hit                = 1'b1;
                    end
                end
            end
            KIND_LOOKUP: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_used[i] && slot_v6[i] == c.v6 &&
                        (addr & lead_mask(c.v6, slot_len[i])) == slot_bits[i]) r.hit = 1'b1;
                end
            end
            KIND_CLEAR: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
                r.hit = 1'b1;
            end
            default: begin
            end
        endcase
        expected_replies.push_back(r);
    endfunction

    function void report(string what, logic want, logic got);
        errors++;
        $display("%0t: %s mismatch, expected %0b actual %0b", $time, what, want, got);
    endfunction

    function void check_word(logic hit, logic full);
        t_prefix_reply want;
        if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, expected none actual %0b/%0b",
                     $time, hit, full);
            return;
        end
        want = expected_replies.pop_front();
        if (want.hit !== hit) report("accepted_or_hit", want.hit, hit);
        if (want.full !== full) report("table_full", want.full, full);
    endfunction
endclass

module tb;

    // generous bound: every word at its longest gap, longest stall and scan time
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned RANDOM_WORDS = 1700;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind            = KIND_INSERT;
    logic        i_is_v6           = 1'b0;
    logic [63:0] i_addr_high       = '0;
    logic [63:0] i_addr_low        = '0;
    logic [7:0]  i_prefix_length   = '0;
    logic        o_out_valid;
    logic        i_out_ready       = 1'b0;
    logic        o_accepted_or_hit;
    logic        o_table_full;

    t_prefix_shadow shadow;
    t_prefix_cmd    recent_prefixes[$];   // well-formed prefixes sent lately, seeds for hits
    logic           sender_calm = 1'b0;   // no gaps on the input side while set
    logic           sink_calm   = 1'b0;   // no stalls on the result side while set

    cidr_prefix_set_match #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_is_v6           (i_is_v6),
        .i_addr_high       (i_addr_high),
        .i_addr_low        (i_addr_low),
        .i_prefix_length   (i_prefix_length),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_accepted_or_hit (o_accepted_or_hit),
        .o_table_full      (o_table_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter, ends a hung run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rand_bit();
        return $urandom_range(0, 1) == 1;
    endfunction

    // mostly short gaps, now and then one longer than a whole table scan
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // legal length, leaning toward the ends and the 64-bit seam of ipv6
    function automatic logic [7:0] pick_len(logic v6);
        logic [7:0] max_len;
        max_len = v6 ? V6_BITS : V4_BITS;
        case ($urandom_range(0, 9))
            0: return 8'd1;
            1: return max_len;
            2: return v6 ? 8'($urandom_range(63, 66)) : 8'($urandom_range(30, 31));
            default: return 8'($urandom_range(1, int'(max_len)));
        endcase
    endfunction

    function automatic t_prefix_cmd make_cmd(logic [1:0] kind, logic v6, logic [63:0] hi,
                                             logic [63:0] lo, logic [7:0] len);
        t_prefix_cmd c;
        c.kind = kind;
        c.v6   = v6;
        c.hi   = hi;
        c.lo   = lo;
        c.len  = len;
        return c;
    endfunction

    // new random prefix for insert, remembered for later hits and duplicates
    function automatic t_prefix_cmd fresh_prefix();
        t_prefix_cmd c;
        c = make_cmd(KIND_INSERT, rand_bit(), rand64(), rand64(), 8'd0);
        c.len = pick_len(c.v6);
        recent_prefixes.push_back(c);
        if (recent_prefixes.size() > 96) void'(recent_prefixes.pop_front());
        return c;
    endfunction

    // same prefix bits with random host bits; poke flips one bit inside the prefix
    function automatic t_prefix_cmd derive(t_prefix_cmd base, logic [1:0] kind, logic poke);
        t_prefix_cmd  c;
        logic [127:0] keep;
        logic [127:0] addr;
        int           pos;
        keep = lead_mask(base.v6, base.len);
        addr = ({base.hi, base.lo} & keep) | ({rand64(), rand64()} & ~keep);
        if (poke) begin
            pos = $urandom_range(0, int'(base.len) - 1);
            addr[(base.v6 ? 127 : 31) - pos] = ~addr[(base.v6 ? 127 : 31) - pos];
        end
        c          = base;
        c.kind     = kind;
        {c.hi, c.lo} = addr;
        if (kind != KIND_INSERT) c.len = 8'($urandom);
        return c;
    endfunction

    function automatic t_prefix_cmd pick_recent();
        return recent_prefixes[$urandom_range(0, recent_prefixes.size() - 1)];
    endfunction

    // hold the word until accepted, then maybe leave a gap
    task automatic send_word(input t_prefix_cmd c);
        int gap;
        i_in_valid      <= 1'b1;
        i_kind          <= c.kind;
        i_is_v6         <= c.v6;
        i_addr_high     <= c.hi;
        i_addr_low      <= c.lo;
        i_prefix_length <= c.len;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_word(c);
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.expected_replies.size() != 0);
    endtask

    // result side: check each accepted word, stall at random
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                shadow.check_word(o_accepted_or_hit, o_table_full);
                if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
                // stall length varies so that it lands on every phase of a table scan
                if (!sink_calm) stall_left = pick_gap();
            end else if (stall_left == 0 && !sink_calm && $urandom_range(0, 31) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_prefix_cmd c;
        t_prefix_cmd first;
        int unsigned sent;
        int          r;
        int          run_len;
        logic        paused;
        shadow = new();
        sent   = 0;
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // lookup on an empty table
        send_word(make_cmd(KIND_LOOKUP, 1'b0, rand64(), rand64(), 8'd24));
        // bad lengths: zero, one past each family's limit, all ones
        send_word(make_cmd(KIND_INSERT, 1'b0, '0, 64'h0A00_0000, 8'd0));
        send_word(make_cmd(KIND_INSERT, 1'b0, '0, 64'h0A00_0000, 8'd33));
        send_word(make_cmd(KIND_INSERT, 1'b1, '1, '1, 8'd129));
        send_word(make_cmd(KIND_INSERT, 1'b1, '1, '1, 8'd255));
        send_word(make_cmd(KIND_INSERT, 1'b0, '1, '1, 8'd255));
        // 10/8 with junk in the ignored upper bits, then the same prefix again
        send_word(make_cmd(KIND_INSERT, 1'b0, '1, 64'hFFFF_FFFF_0A12_3456, 8'd8));
        send_word(make_cmd(KIND_INSERT, 1'b0, '0, 64'h0000_0000_0A00_0001, 8'd8));
        // covered by 10/8 but still its own entry
        send_word(make_cmd(KIND_INSERT, 1'b0, '0, 64'h0A01_0000, 8'd16));
        send_word(make_cmd(KIND_LOOKUP, 1'b0, '1, 64'hDEAD_BEEF_0A01_0203, 8'd0));
        // same low bits but the wrong family
        send_word(make_cmd(KIND_LOOKUP, 1'b1, '0, 64'h0A01_0203, 8'd0));
        send_word(make_cmd(KIND_LOOKUP, 1'b0, '0, 64'h0B00_0000, 8'd0));
        // length extremes for both families
        send_word(make_cmd(KIND_INSERT, 1'b0, '0, 64'hFFFF_FFFF, 8'd32));
        send_word(make_cmd(KIND_INSERT, 1'b0, '0, 64'h8000_0000, 8'd1));
        send_word(make_cmd(KIND_INSERT, 1'b1, '1, '1, 8'd128));
        send_word(make_cmd(KIND_INSERT, 1'b1, '0, '0, 8'd1));
        send_word(make_cmd(KIND_INSERT, 1'b1, 64'h2001_0DB8_0000_0001, '0, 8'd64));
        send_word(make_cmd(KIND_INSERT, 1'b1, 64'h2001_0DB8_0000_0001,
                           64'h8000_0000_0000_0000, 8'd65));
        send_word(make_cmd(KIND_LOOKUP, 1'b1, '1, '1, 8'd7));
        send_word(make_cmd(KIND_LOOKUP, 1'b0, '0, 64'h7FFF_FFFF, 8'd0));
        // unused kind, then clear and look again
        send_word(make_cmd(KIND_UNUSED, 1'b1, rand64(), rand64(), 8'd16));
        send_word(make_cmd(KIND_CLEAR, 1'b0, '0, '0, 8'd0));
        send_word(make_cmd(KIND_LOOKUP, 1'b0, '0, 64'h0A01_0203, 8'd0));
        send_word(make_cmd(KIND_INSERT, 1'b1, '1, '1, 8'd128));

        // ---- random part ----
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 59) == 0) sender_calm = ~sender_calm;
            // once midway: hold off until the block has answered everything
            if (!paused && sent >= RANDOM_WORDS / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r == 0) begin
                // fill run: start empty, insert past capacity, then a duplicate on a full table
                send_word(make_cmd(KIND_CLEAR, rand_bit(), rand64(), rand64(), 8'($urandom)));
                run_len = $urandom_range(66, 74);
                first   = fresh_prefix();
                send_word(first);
                for (int k = 1; k < run_len; k++) begin
                    c = fresh_prefix();
                    send_word(c);
                    if ($urandom_range(0, 3) == 0) begin
                        send_word(derive(c, KIND_LOOKUP, $urandom_range(0, 2) == 0));
                        sent++;
                    end
                end
                send_word(derive(first, KIND_INSERT, 1'b0));
                sent += run_len + 2;
            end else begin
                if (r < 35) begin
                    c = fresh_prefix();
                end else if (r < 45 && recent_prefixes.size() != 0) begin
                    c = derive(pick_recent(), KIND_INSERT, 1'b0);
                end else if (r < 50) begin
                    c = make_cmd(KIND_INSERT, rand_bit(), rand64(), rand64(), 8'd0);
                    if ($urandom_range(0, 3) != 0)
                        c.len = 8'($urandom_range(c.v6 ? 129 : 33, 255));
                end else if (r < 88 && recent_prefixes.size() != 0 &&
                             $urandom_range(0, 3) != 0) begin
                    c = derive(pick_recent(), KIND_LOOKUP, $urandom_range(0, 4) == 0);
                end else if (r < 88) begin
                    c = make_cmd(KIND_LOOKUP, rand_bit(), rand64(), rand64(), 8'($urandom));
                end else if (r < 93) begin
                    c = make_cmd(KIND_CLEAR, rand_bit(), rand64(), rand64(), 8'($urandom));
                end else begin
                    c = make_cmd(KIND_UNUSED, rand_bit(), rand64(), rand64(), 8'($urandom));
                end
                send_word(c);
                sent++;
            end
        end

        // drain, then leave room for any stray word
        wait_results_drained();
        repeat (2 * TABLE_DEPTH + 10) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
